/* src/dgnc_pkg.sv */
// ----------------------------------------------------------------------------
// dgnc_pkg
// types, codes and helpers for the dust gate node controller
// ----------------------------------------------------------------------------
package dgnc_pkg;

    localparam int SAMPLE_WINDOW_MS = 100;
    localparam int WINDOW_W         = 7;

    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 10;
    localparam int MSG_W    = 3;
    localparam int GCODE_W  = 8;
    localparam int TIMER_W  = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_VAL = '1;
    localparam logic [TIMER_W-1:0]  TIMER_SAT      = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_SAMPLE  = 2'd1,
        CMD_MESSAGE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_MACHINE   = 2'd0,
        MODE_COLLECTOR = 2'd1,
        MODE_BRANCH    = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    localparam logic [MSG_W-1:0] MSG_RUNNING = 3'd0;
    localparam logic [MSG_W-1:0] MSG_HELLO   = 3'd2;
    localparam logic [MSG_W-1:0] MSG_ACK     = 3'd4;

    localparam logic [1:0] SEND_RUNNING = 2'd0;
    localparam logic [1:0] SEND_STOPPED = 2'd1;
    localparam logic [1:0] SEND_WELCOME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_WHEN_IDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REBROADCAST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELAY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DELAY        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_CODE       = 3'd7;

    typedef struct packed {
        logic       unknown_message;
        logic       send_flag;
        logic [1:0] send_code;
        logic       send_valid;
        logic       system_active;
        logic       status_on;
        logic       collector_on;
        logic       gate_open;
    } result_t;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        sat_inc = (v == TIMER_SAT) ? TIMER_SAT : v + TIMER_W'(1);
    endfunction

endpackage

/* src/dust_gate_node_controller_top.sv */
// ----------------------------------------------------------------------------
// dust_gate_node_controller_top
// node controller for a dust-extraction system: machine, collector, branch gate
// ----------------------------------------------------------------------------
// requests enter on the s_ group: s_tuser carries the command (tick, adc
// sample, radio message), s_tdata the sample and message fields. each request
// gives one result on the m_ group: gate, collector and status outputs plus an
// optional broadcast request and an unknown-message flag.
// the whole update of one request is done in the accepting cycle; the result
// is registered into the output queue. one request is taken every cycle while
// s_tready is high. results wait in a two-entry output queue, so s_tready
// stays high while one result waits; s_tready drops only when both entries
// are held by a stalled receiver, and no result is lost or dropped.
// the cfg channel writes one register per cycle (cfg_ready is always high);
// it is meant to be used while no request is in flight.
// reset (rst_n low, asynchronous) returns the configuration and node state
// registers to their defaults, empties the output queue and restarts the
// sample window; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module dust_gate_node_controller_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample[9:0], msg_code[12:10], gate_code[20:13], zero fill
    input  logic [dgnc_pkg::IN_DATA_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [dgnc_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // gate_open[0], collector_on[1], status_on[2], system_active[3],
    // send_valid[4], send_code[6:5], send_flag[7], unknown_message[8], zero fill
    output logic [dgnc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dgnc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dgnc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW = dgnc_pkg::TIMER_W;
    localparam int SW = dgnc_pkg::SAMPLE_W;
    localparam int WW = dgnc_pkg::WINDOW_W;

    // configuration
    dgnc_pkg::mode_t       node_mode_reg;
    logic                  close_when_idle_reg;
    logic [SW-1:0]         threshold_reg;
    logic [TW-1:0]         rebroadcast_reg;
    logic [TW-1:0]         close_delay_reg;
    logic [TW-1:0]         hold_delay_reg;
    logic [TW-1:0]         on_delay_reg;
    logic [dgnc_pkg::GCODE_W-1:0] my_gate_code_reg;

    // node state
    logic [WW-1:0] window_elapsed_reg, window_elapsed_next;
    logic [SW-1:0] sample_max_reg, sample_max_next;
    logic [SW-1:0] sample_min_reg, sample_min_next;
    logic          current_flowing_reg, current_flowing_next;
    logic [TW-1:0] since_broadcast_reg, since_broadcast_next;
    logic          idle_active_reg, idle_active_next;
    logic [TW-1:0] idle_elapsed_reg, idle_elapsed_next;
    logic          hold_active_reg, hold_active_next;
    logic [TW-1:0] hold_elapsed_reg, hold_elapsed_next;
    logic          start_pending_reg, start_pending_next;
    logic [TW-1:0] start_elapsed_reg, start_elapsed_next;
    logic          gate_is_open_reg, gate_is_open_next;
    logic          collector_running_reg, collector_running_next;

    // output queue
    dgnc_pkg::result_t out0_reg, out1_reg;
    dgnc_pkg::result_t result;
    logic [1:0]        cnt_reg;

    logic in_acc, out_acc, flowing, wpos;
    logic [SW-1:0] sample;
    logic [dgnc_pkg::MSG_W-1:0] msg_code;
    logic [dgnc_pkg::GCODE_W-1:0] gate_code;
    dgnc_pkg::cmd_t command;

    assign command   = dgnc_pkg::cmd_t'(s_tuser);
    assign sample    = s_tdata[9:0];
    assign msg_code  = s_tdata[12:10];
    assign gate_code = s_tdata[20:13];

    assign s_tready  = (cnt_reg != 2'd2);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign out_acc   = m_tvalid && m_tready;
    assign m_tdata   = {7'd0, out0_reg};
    assign cfg_ready = 1'b1;

    assign flowing = (sample_max_reg >= sample_min_reg) &&
                     ((sample_max_reg - sample_min_reg) >= threshold_reg);

    always_comb
    begin
        window_elapsed_next    = window_elapsed_reg;
        sample_max_next        = sample_max_reg;
        sample_min_next        = sample_min_reg;
        current_flowing_next   = current_flowing_reg;
        since_broadcast_next   = since_broadcast_reg;
        idle_active_next       = idle_active_reg;
        idle_elapsed_next      = idle_elapsed_reg;
        hold_active_next       = hold_active_reg;
        hold_elapsed_next      = hold_elapsed_reg;
        start_pending_next     = start_pending_reg;
        start_elapsed_next     = start_elapsed_reg;
        gate_is_open_next      = gate_is_open_reg;
        collector_running_next = collector_running_reg;
        result                 = '0;

        case (command)
            dgnc_pkg::CMD_TICK:
            begin
                since_broadcast_next = dgnc_pkg::sat_inc(since_broadcast_reg);
                if (idle_active_reg)
                    idle_elapsed_next = dgnc_pkg::sat_inc(idle_elapsed_reg);
                if (hold_active_reg)
                    hold_elapsed_next = dgnc_pkg::sat_inc(hold_elapsed_reg);
                if (start_pending_reg)
                    start_elapsed_next = dgnc_pkg::sat_inc(start_elapsed_reg);
                case (node_mode_reg)
                    dgnc_pkg::MODE_MACHINE:
                    begin
                        window_elapsed_next = window_elapsed_reg + WW'(1);
                        if (window_elapsed_next >= WW'(dgnc_pkg::SAMPLE_WINDOW_MS))
                        begin
                            if (flowing)
                            begin
                                if (!current_flowing_reg ||
                                    since_broadcast_next > rebroadcast_reg)
                                begin
                                    since_broadcast_next = '0;
                                    current_flowing_next = 1'b1;
                                    gate_is_open_next    = 1'b1;
                                    result.system_active = 1'b1;
                                    result.send_valid    = 1'b1;
                                    result.send_code     = dgnc_pkg::SEND_RUNNING;
                                end
                            end
                            else if (current_flowing_reg)
                            begin
                                current_flowing_next = 1'b0;
                                idle_active_next     = 1'b1;
                                idle_elapsed_next    = '0;
                                result.send_valid    = 1'b1;
                                result.send_code     = dgnc_pkg::SEND_STOPPED;
                            end
                            else if (close_when_idle_reg && idle_active_reg &&
                                     idle_elapsed_next > close_delay_reg)
                            begin
                                gate_is_open_next = 1'b0;
                                idle_active_next  = 1'b0;
                            end
                            window_elapsed_next = '0;
                            sample_max_next     = '0;
                            sample_min_next     = dgnc_pkg::SAMPLE_MAX_VAL;
                        end
                    end
                    dgnc_pkg::MODE_COLLECTOR:
                    begin
                        if (start_pending_reg && start_elapsed_next >= on_delay_reg)
                        begin
                            start_pending_next     = 1'b0;
                            collector_running_next = 1'b1;
                            hold_active_next       = 1'b1;
                            hold_elapsed_next      = '0;
                        end
                        if (!start_pending_next && hold_active_next &&
                            hold_elapsed_next > hold_delay_reg)
                        begin
                            hold_active_next       = 1'b0;
                            collector_running_next = 1'b0;
                        end
                    end
                    dgnc_pkg::MODE_BRANCH:
                    begin
                        if (hold_active_reg && hold_elapsed_next > hold_delay_reg)
                        begin
                            hold_active_next  = 1'b0;
                            gate_is_open_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            dgnc_pkg::CMD_SAMPLE:
            begin
                if (sample > sample_max_reg)
                    sample_max_next = sample;
                if (sample < sample_min_reg)
                    sample_min_next = sample;
            end
            dgnc_pkg::CMD_MESSAGE:
            begin
                if (msg_code == dgnc_pkg::MSG_RUNNING)
                begin
                    result.system_active = 1'b1;
                    case (node_mode_reg)
                        dgnc_pkg::MODE_COLLECTOR:
                        begin
                            if (!collector_running_reg && !start_pending_reg)
                            begin
                                if (gate_code != '0 && on_delay_reg != '0)
                                begin
                                    start_pending_next = 1'b1;
                                    start_elapsed_next = '0;
                                end
                                else
                                    collector_running_next = 1'b1;
                            end
                            hold_active_next  = 1'b1;
                            hold_elapsed_next = '0;
                        end
                        dgnc_pkg::MODE_MACHINE:
                        begin
                            if (!current_flowing_reg)
                                gate_is_open_next = 1'b0;
                        end
                        dgnc_pkg::MODE_BRANCH:
                        begin
                            if ((gate_code & my_gate_code_reg) != '0)
                            begin
                                gate_is_open_next = 1'b1;
                                hold_active_next  = 1'b1;
                                hold_elapsed_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (msg_code == dgnc_pkg::MSG_HELLO)
                begin
                    result.send_valid    = 1'b1;
                    result.send_code     = dgnc_pkg::SEND_WELCOME;
                    result.system_active = 1'b1;
                end
                else if (msg_code > dgnc_pkg::MSG_ACK)
                    result.unknown_message = 1'b1;
            end
            default:
            begin
            end
        endcase

        result.send_flag    = result.send_valid &&
                              (result.send_code == dgnc_pkg::SEND_RUNNING);
        result.gate_open    = gate_is_open_next;
        result.collector_on = collector_running_next;
        case (node_mode_reg)
            dgnc_pkg::MODE_MACHINE:   result.status_on = current_flowing_next;
            dgnc_pkg::MODE_COLLECTOR: result.status_on = collector_running_next;
            dgnc_pkg::MODE_BRANCH:    result.status_on = gate_is_open_next;
            default:                  result.status_on = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_mode_reg       <= dgnc_pkg::MODE_MACHINE;
            close_when_idle_reg <= 1'b1;
            threshold_reg       <= SW'(100);
            rebroadcast_reg     <= TW'(5000);
            close_delay_reg     <= TW'(10000);
            hold_delay_reg      <= TW'(15000);
            on_delay_reg        <= TW'(1000);
            my_gate_code_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dgnc_pkg::REG_NODE_MODE:       node_mode_reg <= dgnc_pkg::mode_t'(cfg_data[1:0]);
                dgnc_pkg::REG_CLOSE_WHEN_IDLE: close_when_idle_reg <= cfg_data[0];
                dgnc_pkg::REG_THRESHOLD:       threshold_reg <= cfg_data[SW-1:0];
                dgnc_pkg::REG_REBROADCAST:     rebroadcast_reg <= cfg_data;
                dgnc_pkg::REG_CLOSE_DELAY:     close_delay_reg <= cfg_data;
                dgnc_pkg::REG_HOLD_DELAY:      hold_delay_reg <= cfg_data;
                dgnc_pkg::REG_ON_DELAY:        on_delay_reg <= cfg_data;
                dgnc_pkg::REG_GATE_CODE:       my_gate_code_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_elapsed_reg    <= '0;
            sample_max_reg        <= '0;
            sample_min_reg        <= dgnc_pkg::SAMPLE_MAX_VAL;
            current_flowing_reg   <= 1'b0;
            since_broadcast_reg   <= dgnc_pkg::TIMER_SAT;
            idle_active_reg       <= 1'b0;
            idle_elapsed_reg      <= '0;
            hold_active_reg       <= 1'b0;
            hold_elapsed_reg      <= '0;
            start_pending_reg     <= 1'b0;
            start_elapsed_reg     <= '0;
            gate_is_open_reg      <= 1'b0;
            collector_running_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            window_elapsed_reg    <= window_elapsed_next;
            sample_max_reg        <= sample_max_next;
            sample_min_reg        <= sample_min_next;
            current_flowing_reg   <= current_flowing_next;
            since_broadcast_reg   <= since_broadcast_next;
            idle_active_reg       <= idle_active_next;
            idle_elapsed_reg      <= idle_elapsed_next;
            hold_active_reg       <= hold_active_next;
            hold_elapsed_reg      <= hold_elapsed_next;
            start_pending_reg     <= start_pending_next;
            start_elapsed_reg     <= start_elapsed_next;
            gate_is_open_reg      <= gate_is_open_next;
            collector_running_reg <= collector_running_next;
        end
    end

    // write slot after an optional pop
    assign wpos = (cnt_reg == 2'd2) || ((cnt_reg == 2'd1) && !out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !wpos)
            out0_reg <= result;
        else if (out_acc)
            out0_reg <= out1_reg;
        if (in_acc && wpos)
            out1_reg <= result;
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue overflow");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        window_elapsed_reg < WW'(dgnc_pkg::SAMPLE_WINDOW_MS))
        else $error("sample window out of range");

    a_pending_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        start_pending_reg |-> !collector_running_reg)
        else $error("collector running with start pending");

    a_sample_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == dgnc_pkg::CMD_SAMPLE) |=>
        (sample_max_reg >= $past(sample)) && (sample_min_reg <= $past(sample)))
        else $error("sample not covered by window extremes");

    a_flag_with_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out0_reg.send_flag) |->
        (out0_reg.send_valid && out0_reg.send_code == dgnc_pkg::SEND_RUNNING))
        else $error("send flag without running broadcast");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dust gate node controller
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a clocked driver on the s_ group and a
// clocked monitor takes results from the m_ group. every accepted request is
// run through a local model of the node (machine window, broadcast, idle,
// hold and start timers) and the predicted outputs are compared field by
// field with the results in order. the run starts with directed requests,
// then goes through machine, collector, branch gate and no-mode settings
// with random window swings, message bursts, noise and idle bursts on both
// sides, one long receiver stall and a drain before each set of register writes.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        dgnc_pkg::cmd_t                 cmd;
        logic [dgnc_pkg::GCODE_W-1:0]   gcode;
        logic [dgnc_pkg::MSG_W-1:0]     msg;
        logic [dgnc_pkg::SAMPLE_W-1:0]  sample;
    } node_req_t;

    typedef enum int {
        WIN_EMPTY,
        WIN_QUIET,
        WIN_BUSY,
        WIN_EDGE
    } swing_t;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [dgnc_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
    logic [dgnc_pkg::CMD_W-1:0]       s_tuser   = dgnc_pkg::CMD_TICK;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [dgnc_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dgnc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dgnc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // register shadows
    dgnc_pkg::mode_t                  mode_r       = dgnc_pkg::MODE_MACHINE;
    logic                             idle_close_r = 1'b1;
    logic [dgnc_pkg::SAMPLE_W-1:0]    thresh_r     = 10'd100;
    logic [dgnc_pkg::TIMER_W-1:0]     rebcast_r    = 16'd5000;
    logic [dgnc_pkg::TIMER_W-1:0]     close_dly_r  = 16'd10000;
    logic [dgnc_pkg::TIMER_W-1:0]     hold_dly_r   = 16'd15000;
    logic [dgnc_pkg::TIMER_W-1:0]     on_dly_r     = 16'd1000;
    logic [dgnc_pkg::GCODE_W-1:0]     mask_r       = 8'd0;

    // node state
    logic [dgnc_pkg::WINDOW_W-1:0]    win_count  = '0;
    logic [dgnc_pkg::SAMPLE_W-1:0]    peak_hi    = '0;
    logic [dgnc_pkg::SAMPLE_W-1:0]    peak_lo    = '1;
    logic                             flowing_q  = 1'b0;
    logic [dgnc_pkg::TIMER_W-1:0]     bcast_age  = '1;
    logic                             idle_run   = 1'b0;
    logic [dgnc_pkg::TIMER_W-1:0]     idle_age   = '0;
    logic                             hold_run   = 1'b0;
    logic [dgnc_pkg::TIMER_W-1:0]     hold_age   = '0;
    logic                             start_wait = 1'b0;
    logic [dgnc_pkg::TIMER_W-1:0]     start_age  = '0;
    logic                             gate_q     = 1'b0;
    logic                             coll_q     = 1'b0;

    node_req_t                        pending_reqs[$];
    dgnc_pkg::result_t                predicted_outputs[$];
    node_req_t                        held_req;

    int                     src_pct = 0;
    int                     sink_pct = 0;
    int                     src_gap = 0;
    int                     sink_gap = 0;
    logic                   sink_stall = 1'b0;

    int                     n_req = 0;
    int                     n_res = 0;
    int                     n_bcast = 0;
    int                     n_unknown = 0;
    int                     win_evals = 0;
    int                     mismatches = 0;
    int unsigned            cycles = 0;

    dust_gate_node_controller_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [dgnc_pkg::TIMER_W-1:0] bump_timer(
        input logic [dgnc_pkg::TIMER_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic dgnc_pkg::result_t predict_node_step(input node_req_t r);
        dgnc_pkg::result_t res;
        logic        act;
        logic        snd;
        logic        unk;
        logic [1:0]  code;
        logic        flow_now;
        act  = 1'b0;
        snd  = 1'b0;
        unk  = 1'b0;
        code = dgnc_pkg::SEND_RUNNING;
        case (r.cmd)
            dgnc_pkg::CMD_TICK:
            begin
                bcast_age = bump_timer(bcast_age);
                if (idle_run) idle_age = bump_timer(idle_age);
                if (hold_run) hold_age = bump_timer(hold_age);
                if (start_wait) start_age = bump_timer(start_age);
                if (mode_r == dgnc_pkg::MODE_MACHINE)
                begin
                    win_count = win_count + 1'b1;
                    if (win_count >= dgnc_pkg::SAMPLE_WINDOW_MS)
                    begin
                        win_evals++;
                        flow_now = (peak_hi >= peak_lo) &&
                                   ((peak_hi - peak_lo) >= thresh_r);
                        if (flow_now)
                        begin
                            if (!flowing_q || bcast_age > rebcast_r)
                            begin
                                bcast_age = '0;
                                flowing_q = 1'b1;
                                gate_q    = 1'b1;
                                act       = 1'b1;
                                snd       = 1'b1;
                                code      = dgnc_pkg::SEND_RUNNING;
                            end
                        end
                        else if (flowing_q)
                        begin
                            flowing_q = 1'b0;
                            idle_run  = 1'b1;
                            idle_age  = '0;
                            snd       = 1'b1;
                            code      = dgnc_pkg::SEND_STOPPED;
                        end
                        else if (idle_close_r && idle_run && idle_age > close_dly_r)
                        begin
                            gate_q   = 1'b0;
                            idle_run = 1'b0;
                        end
                        win_count = '0;
                        peak_hi   = '0;
                        peak_lo   = '1;
                    end
                end
                else if (mode_r == dgnc_pkg::MODE_COLLECTOR)
                begin
                    if (start_wait && start_age >= on_dly_r)
                    begin
                        start_wait = 1'b0;
                        coll_q     = 1'b1;
                        hold_run   = 1'b1;
                        hold_age   = '0;
                    end
                    if (!start_wait && hold_run && hold_age > hold_dly_r)
                    begin
                        hold_run = 1'b0;
                        coll_q   = 1'b0;
                    end
                end
                else if (mode_r == dgnc_pkg::MODE_BRANCH)
                begin
                    if (hold_run && hold_age > hold_dly_r)
                    begin
                        hold_run = 1'b0;
                        gate_q   = 1'b0;
                    end
                end
            end
            dgnc_pkg::CMD_SAMPLE:
            begin
                if (r.sample > peak_hi) peak_hi = r.sample;
                if (r.sample < peak_lo) peak_lo = r.sample;
            end
            dgnc_pkg::CMD_MESSAGE:
            begin
                if (r.msg == dgnc_pkg::MSG_RUNNING)
                begin
                    act = 1'b1;
                    if (mode_r == dgnc_pkg::MODE_COLLECTOR)
                    begin
                        if (!coll_q && !start_wait)
                        begin
                            if (r.gcode != '0 && on_dly_r != '0)
                            begin
                                start_wait = 1'b1;
                                start_age  = '0;
                            end
                            else
                            begin
                                coll_q = 1'b1;
                            end
                        end
                        hold_run = 1'b1;
                        hold_age = '0;
                    end
                    else if (mode_r == dgnc_pkg::MODE_MACHINE)
                    begin
                        if (!flowing_q) gate_q = 1'b0;
                    end
                    else if (mode_r == dgnc_pkg::MODE_BRANCH)
                    begin
                        if ((r.gcode & mask_r) != '0)
                        begin
                            gate_q   = 1'b1;
                            hold_run = 1'b1;
                            hold_age = '0;
                        end
                    end
                end
                else if (r.msg == dgnc_pkg::MSG_HELLO)
                begin
                    snd  = 1'b1;
                    code = dgnc_pkg::SEND_WELCOME;
                    act  = 1'b1;
                end
                else if (r.msg > dgnc_pkg::MSG_ACK)
                begin
                    unk = 1'b1;
                end
            end
            default: ;
        endcase
        res.gate_open       = gate_q;
        res.collector_on    = coll_q;
        case (mode_r)
            dgnc_pkg::MODE_MACHINE:   res.status_on = flowing_q;
            dgnc_pkg::MODE_COLLECTOR: res.status_on = coll_q;
            dgnc_pkg::MODE_BRANCH:    res.status_on = gate_q;
            default:                  res.status_on = 1'b0;
        endcase
        res.system_active   = act;
        res.send_valid      = snd;
        res.send_code       = snd ? code : dgnc_pkg::SEND_RUNNING;
        res.send_flag       = snd && (code == dgnc_pkg::SEND_RUNNING);
        res.unknown_message = unk;
        return res;
    endfunction

    function automatic string show(input dgnc_pkg::result_t r);
        return $sformatf("gate=%b coll=%b status=%b active=%b send=%b code=%0d flag=%b unk=%b",
                         r.gate_open, r.collector_on, r.status_on, r.system_active,
                         r.send_valid, r.send_code, r.send_flag, r.unknown_message);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_outputs.push_back(predict_node_step(held_req));
                n_req++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (src_pct != 0 && $urandom_range(1, 100) <= src_pct)
                begin
                    src_gap = $urandom_range(0, 18);
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    held_req = pending_reqs.pop_front();
                    s_tdata  <= dgnc_pkg::IN_DATA_W'({held_req.gcode, held_req.msg,
                                                      held_req.sample});
                    s_tuser  <= held_req.cmd;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        dgnc_pkg::result_t got;
        dgnc_pkg::result_t want;
        logic [dgnc_pkg::OUT_DATA_W-$bits(dgnc_pkg::result_t)-1:0] fill;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got  = dgnc_pkg::result_t'(m_tdata[$bits(dgnc_pkg::result_t)-1:0]);
                fill = m_tdata[dgnc_pkg::OUT_DATA_W-1:$bits(dgnc_pkg::result_t)];
                n_res++;
                if (got.send_valid) n_bcast++;
                if (got.unknown_message) n_unknown++;
                if (predicted_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing predicted: %s",
                                 n_res, show(got));
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (got.gate_open !== want.gate_open
                        || got.collector_on !== want.collector_on
                        || got.status_on !== want.status_on
                        || got.system_active !== want.system_active
                        || got.send_valid !== want.send_valid
                        || got.send_code !== want.send_code
                        || got.send_flag !== want.send_flag
                        || got.unknown_message !== want.unknown_message
                        || fill !== '0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch: expected %s, got %s fill=%h",
                                     n_res, show(want), show(got), fill);
                    end
                end
            end
            if (sink_stall)
            begin
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (sink_pct != 0 && $urandom_range(1, 100) <= sink_pct)
            begin
                sink_gap = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer(input dgnc_pkg::cmd_t c, input int unsigned s,
                         input int unsigned m, input int unsigned g);
        node_req_t r;
        r.cmd    = c;
        r.sample = dgnc_pkg::SAMPLE_W'(s);
        r.msg    = dgnc_pkg::MSG_W'(m);
        r.gcode  = dgnc_pkg::GCODE_W'(g);
        pending_reqs.push_back(r);
    endtask

    task automatic offer_tick();
        offer(dgnc_pkg::CMD_TICK, $urandom_range(0, 1023), $urandom_range(0, 7),
              $urandom_range(0, 255));
    endtask

    task automatic offer_noise(input bit with_sample);
        dgnc_pkg::cmd_t c;
        c = dgnc_pkg::cmd_t'($urandom_range(0, 3));
        if (c == dgnc_pkg::CMD_TICK || (c == dgnc_pkg::CMD_SAMPLE && !with_sample))
            c = dgnc_pkg::CMD_MESSAGE;
        offer(c, $urandom_range(0, 1023), $urandom_range(0, 7), $urandom_range(0, 255));
    endtask

    // one sample window of the given number of ticks with a random current swing
    task automatic gen_window(input int ticks);
        swing_t kind;
        int     th;
        int     span;
        int     lo;
        int     hi;
        int     t;
        int     pick;
        th   = int'(thresh_r);
        pick = $urandom_range(0, 9);
        kind = (pick == 0) ? WIN_EMPTY : (pick < 5) ? WIN_BUSY : (pick < 8) ? WIN_QUIET : WIN_EDGE;
        case (kind)
            WIN_BUSY:  span = th + $urandom_range(0, 1023 - th);
            WIN_QUIET: span = (th == 0) ? 0 : $urandom_range(0, th - 1);
            WIN_EDGE:  span = (th == 0) ? 0 : th - $urandom_range(0, 1);
            default:   span = 0;
        endcase
        lo = $urandom_range(0, 1023 - span);
        hi = lo + span;
        for (t = 0; t < ticks; t++)
        begin
            if (kind != WIN_EMPTY && t < ticks - 1)
            begin
                if (t == ticks / 4)
                    offer(dgnc_pkg::CMD_SAMPLE, lo, $urandom_range(0, 7),
                          $urandom_range(0, 255));
                else if (t == ticks / 2)
                    offer(dgnc_pkg::CMD_SAMPLE, hi, $urandom_range(0, 7),
                          $urandom_range(0, 255));
                else if ($urandom_range(0, 15) == 0)
                    offer(dgnc_pkg::CMD_SAMPLE, $urandom_range(lo, hi), $urandom_range(0, 7),
                          $urandom_range(0, 255));
            end
            if ($urandom_range(0, 39) == 0) offer_noise(1'b0);
            offer_tick();
        end
    endtask

    task automatic gen_machine(input int windows);
        gen_window(dgnc_pkg::SAMPLE_WINDOW_MS - int'(win_count));
        repeat (windows - 1) gen_window(dgnc_pkg::SAMPLE_WINDOW_MS);
    endtask

    // running messages followed by runs of ticks, with some noise in between
    task automatic gen_bursts(input int bursts);
        int unsigned g;
        int          span;
        int          run;
        int          n;
        repeat (bursts)
        begin
            g = $urandom_range(1, 255);
            if (mode_r == dgnc_pkg::MODE_BRANCH)
            begin
                if ($urandom_range(0, 1)) g = g | mask_r;
                else g = g & ~mask_r;
            end
            else if ($urandom_range(0, 1))
            begin
                g = 0;
            end
            offer(dgnc_pkg::CMD_MESSAGE, $urandom_range(0, 1023), dgnc_pkg::MSG_RUNNING, g);
            span = int'(hold_dly_r) + int'(on_dly_r);
            run  = $urandom_range(0, 3 + ((span > 30) ? 30 : span));
            for (n = 0; n < run; n++)
            begin
                if ($urandom_range(0, 11) == 0)
                    offer_noise(1'b1);
                else if ($urandom_range(0, 24) == 0)
                    offer(dgnc_pkg::CMD_MESSAGE, $urandom_range(0, 1023),
                          dgnc_pkg::MSG_RUNNING, $urandom_range(0, 255));
                offer_tick();
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || predicted_outputs.size() != 0);
    endtask

    task automatic new_phase(input int src, input int sink);
        wait_drained();
        src_pct  = src;
        sink_pct = sink;
    endtask

    task automatic write_reg(input logic [dgnc_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= dgnc_pkg::CFG_DATA_W'(val);
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dgnc_pkg::REG_NODE_MODE:       mode_r       = dgnc_pkg::mode_t'(val[1:0]);
            dgnc_pkg::REG_CLOSE_WHEN_IDLE: idle_close_r = val[0];
            dgnc_pkg::REG_THRESHOLD:       thresh_r     = val[dgnc_pkg::SAMPLE_W-1:0];
            dgnc_pkg::REG_REBROADCAST:     rebcast_r    = val[dgnc_pkg::TIMER_W-1:0];
            dgnc_pkg::REG_CLOSE_DELAY:     close_dly_r  = val[dgnc_pkg::TIMER_W-1:0];
            dgnc_pkg::REG_HOLD_DELAY:      hold_dly_r   = val[dgnc_pkg::TIMER_W-1:0];
            dgnc_pkg::REG_ON_DELAY:        on_dly_r     = val[dgnc_pkg::TIMER_W-1:0];
            dgnc_pkg::REG_GATE_CODE:       mask_r       = val[dgnc_pkg::GCODE_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_pct  = 6;
        sink_pct = 6;

        // field extremes, every message code, the ignored command
        offer(dgnc_pkg::CMD_SAMPLE, 1023, 0, 0);
        offer(dgnc_pkg::CMD_SAMPLE, 0, 7, 255);
        for (k = 0; k < 8; k++)
            offer(dgnc_pkg::CMD_MESSAGE, k * 100, k, k[0] ? 255 : 0);
        offer(dgnc_pkg::CMD_NONE, 1023, 7, 255);
        offer(dgnc_pkg::CMD_TICK, 10'h155, 5, 8'haa);
        offer(dgnc_pkg::CMD_TICK, 10'h2aa, 2, 8'h55);

        // delayed collector start, repeated running while pending, hold expiry
        new_phase(6, 6);
        write_reg(dgnc_pkg::REG_NODE_MODE, dgnc_pkg::MODE_COLLECTOR);
        write_reg(dgnc_pkg::REG_ON_DELAY, 3);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 2);
        @(negedge clk);
        offer(dgnc_pkg::CMD_MESSAGE, 0, dgnc_pkg::MSG_RUNNING, 8'h01);
        offer(dgnc_pkg::CMD_TICK, 0, 0, 0);
        offer(dgnc_pkg::CMD_MESSAGE, 0, dgnc_pkg::MSG_RUNNING, 8'h80);
        repeat (5) offer(dgnc_pkg::CMD_TICK, 0, 0, 0);
        offer(dgnc_pkg::CMD_MESSAGE, 0, dgnc_pkg::MSG_RUNNING, 0);
        offer(dgnc_pkg::CMD_TICK, 0, 0, 0);

        // machine node, with one long receiver stall
        new_phase(8, 8);
        write_reg(dgnc_pkg::REG_NODE_MODE, dgnc_pkg::MODE_MACHINE);
        write_reg(dgnc_pkg::REG_REBROADCAST, 150);
        write_reg(dgnc_pkg::REG_CLOSE_DELAY, 120);
        @(negedge clk);
        gen_machine(2);
        @(posedge clk);
        sink_stall <= 1'b1;
        repeat (300) @(posedge clk);
        sink_stall <= 1'b0;

        new_phase(0, 0);
        write_reg(dgnc_pkg::REG_THRESHOLD, 0);
        write_reg(dgnc_pkg::REG_REBROADCAST, 0);
        write_reg(dgnc_pkg::REG_CLOSE_DELAY, 0);
        write_reg(dgnc_pkg::REG_CLOSE_WHEN_IDLE, 0);
        @(negedge clk);
        gen_machine(2);

        new_phase(4, 4);
        write_reg(dgnc_pkg::REG_THRESHOLD, 1023);
        write_reg(dgnc_pkg::REG_REBROADCAST, 65535);
        write_reg(dgnc_pkg::REG_CLOSE_DELAY, 65535);
        write_reg(dgnc_pkg::REG_CLOSE_WHEN_IDLE, 1);
        @(negedge clk);
        gen_machine(1);

        new_phase(8, 10);
        write_reg(dgnc_pkg::REG_THRESHOLD, $urandom_range(40, 400));
        write_reg(dgnc_pkg::REG_REBROADCAST, 250);
        write_reg(dgnc_pkg::REG_CLOSE_DELAY, 60);
        @(negedge clk);
        gen_machine(2);

        // collector node
        new_phase(10, 8);
        write_reg(dgnc_pkg::REG_NODE_MODE, dgnc_pkg::MODE_COLLECTOR);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 10);
        write_reg(dgnc_pkg::REG_ON_DELAY, 4);
        @(negedge clk);
        gen_bursts(8);

        new_phase(6, 6);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 0);
        write_reg(dgnc_pkg::REG_ON_DELAY, 0);
        @(negedge clk);
        gen_bursts(10);

        new_phase(0, 0);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 65535);
        write_reg(dgnc_pkg::REG_ON_DELAY, 65535);
        @(negedge clk);
        gen_bursts(3);

        // branch gate node
        new_phase(8, 8);
        write_reg(dgnc_pkg::REG_NODE_MODE, dgnc_pkg::MODE_BRANCH);
        write_reg(dgnc_pkg::REG_GATE_CODE, 8'h5a);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 8);
        @(negedge clk);
        gen_bursts(6);

        new_phase(10, 6);
        write_reg(dgnc_pkg::REG_GATE_CODE, 8'hff);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 0);
        @(negedge clk);
        gen_bursts(5);

        new_phase(4, 4);
        write_reg(dgnc_pkg::REG_GATE_CODE, 0);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 65535);
        @(negedge clk);
        gen_bursts(3);

        // no mode selected, then collector again, without idling
        new_phase(0, 0);
        write_reg(dgnc_pkg::REG_NODE_MODE, dgnc_pkg::MODE_NONE);
        @(negedge clk);
        repeat (40)
        begin
            if ($urandom_range(0, 2) == 0) offer_tick();
            else offer_noise(1'b1);
        end

        new_phase(0, 0);
        write_reg(dgnc_pkg::REG_NODE_MODE, dgnc_pkg::MODE_COLLECTOR);
        write_reg(dgnc_pkg::REG_HOLD_DELAY, 20);
        write_reg(dgnc_pkg::REG_ON_DELAY, 12);
        @(negedge clk);
        gen_bursts(6);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("run covered %0d requests over machine, collector, branch gate and no-mode %s",
                 n_req, "settings");
        $display("%0d results checked, %0d broadcasts, %0d unknown messages, %0d windows, %0d cycles",
                 n_res, n_bcast, n_unknown, win_evals, cycles);
        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/dgnc_pkg.sv
src/dust_gate_node_controller_top.sv
tb/testbench.sv
